/* rtl/assert_macros.svh */
// Assertion helpers for the I2C bit sequencer RTL.
// Each macro expects clk_i and rst_ni to be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed: always");

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

`endif

/* rtl/i2cbs_pkg.sv */
// Shared types and constants for the I2C master bit sequencer.
// No dependencies; used by i2cbs_step and the top level.
package i2cbs_pkg;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Last action index of each command kind.
  localparam logic [4:0] EDGE_LAST = 5'd3;
  localparam logic [4:0] BYTE_LAST = 5'd26;
  // First action index of the acknowledge slot (eight bits of three actions).
  localparam logic [4:0] ACK_FIRST = 5'd24;

  // Action within a three-action bit slot.
  localparam logic [1:0] SLOT_SCL_LOW  = 2'd0;
  localparam logic [1:0] SLOT_SDA_SET  = 2'd1;
  localparam logic [1:0] SLOT_SCL_HIGH = 2'd2;

  typedef struct packed {
    logic [4:0] phase;
    logic [1:0] slot;
    logic [2:0] command;
    logic [7:0] shift;
    logic [7:0] rx;
    logic       scl;
    logic       sda;
    logic       ack;
    logic       mst_ack;
  } state_t;

  // Idle, both lines released high, everything else cleared.
  localparam state_t STATE_RST = '{
    phase:   5'd0,
    slot:    SLOT_SCL_LOW,
    command: OP_NONE,
    shift:   8'd0,
    rx:      8'd0,
    scl:     1'b1,
    sda:     1'b1,
    ack:     1'b0,
    mst_ack: 1'b0
  };

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       tgt_acked;
  } result_t;

endpackage

/* rtl/i2cbs_step.sv */
// One-tick next-state and result logic of the I2C bit sequencer.
// Depends on i2cbs_pkg for the state, item and result types.
module i2cbs_step (
  input  i2cbs_pkg::state_t  state_i,
  input  i2cbs_pkg::item_t   item_i,
  output i2cbs_pkg::state_t  state_o,
  output i2cbs_pkg::result_t result_o
);

  logic             idle;
  logic             launch;
  logic             run;
  logic             is_byte;
  logic             last;
  logic             in_ack;
  i2cbs_pkg::state_t s;

  assign idle   = (state_i.phase == 5'd0);
  assign launch = idle && (item_i.opcode inside {[i2cbs_pkg::OP_START:i2cbs_pkg::OP_READ]});
  assign run    = launch || !idle;

  always_comb begin
    s = state_i;
    // Latch the command operands on acceptance.
    if (launch) begin
      s.command = item_i.opcode;
      if (item_i.opcode == i2cbs_pkg::OP_WRITE) begin
        s.shift = item_i.write_data;
      end
      if (item_i.opcode == i2cbs_pkg::OP_READ) begin
        s.mst_ack = item_i.send_ack;
        s.rx      = 8'd0;
      end
    end

    is_byte = (s.command == i2cbs_pkg::OP_WRITE) || (s.command == i2cbs_pkg::OP_READ);
    in_ack  = (s.phase >= i2cbs_pkg::ACK_FIRST);
    last    = (s.phase == (is_byte ? i2cbs_pkg::BYTE_LAST : i2cbs_pkg::EDGE_LAST));

    if (run) begin
      if (!is_byte) begin
        // Start: SCL low, SDA high, SCL high, SDA low. Stop mirrors SDA.
        case (s.phase[1:0])
          2'd0:    s.scl = 1'b0;
          2'd1:    s.sda = (s.command == i2cbs_pkg::OP_START);
          2'd2:    s.scl = 1'b1;
          default: s.sda = (s.command != i2cbs_pkg::OP_START);
        endcase
      end else begin
        case (s.slot)
          i2cbs_pkg::SLOT_SCL_LOW: s.scl = 1'b0;
          i2cbs_pkg::SLOT_SDA_SET: begin
            if (in_ack) begin
              s.sda = (s.command == i2cbs_pkg::OP_WRITE) ? 1'b1 : ~s.mst_ack;
            end else begin
              s.sda = (s.command == i2cbs_pkg::OP_WRITE) ? s.shift[7] : 1'b1;
            end
          end
          default: begin
            s.scl = 1'b1;
            if (in_ack) begin
              if (s.command == i2cbs_pkg::OP_WRITE) begin
                s.ack = ~item_i.sda_sample;
              end
            end else if (s.command == i2cbs_pkg::OP_WRITE) begin
              s.shift = {s.shift[6:0], 1'b0};
            end else begin
              s.rx = {s.rx[6:0], item_i.sda_sample};
            end
          end
        endcase
      end

      // Advance the action counters; drop back to idle after the last action.
      if (last) begin
        s.phase = 5'd0;
        s.slot  = i2cbs_pkg::SLOT_SCL_LOW;
      end else begin
        s.phase = s.phase + 5'd1;
        s.slot  = (s.slot == i2cbs_pkg::SLOT_SCL_HIGH) ? i2cbs_pkg::SLOT_SCL_LOW
                                                         : s.slot + 2'd1;
      end
    end
  end

  assign state_o              = s;
  assign result_o.scl_level   = s.scl;
  assign result_o.sda_level   = s.sda;
  assign result_o.busy_res    = (s.phase != 5'd0);
  assign result_o.done_res    = run && last;
  assign result_o.read_byte   = s.rx;
  assign result_o.tgt_acked   = s.ack;

endmodule

/* rtl/i2c_master_bit_sequencer.sv */
// I2C master bit sequencer: one SCL/SDA pin action per accepted beat while a command runs.
// Results are registered, one per beat; 1 beat per cycle while m_tready_i is high.
// The output register decouples the sides: a new beat enters in the cycle the last drains.
// Reset (rst_ni low, async): idle, SCL and SDA released high, all but result data cleared.
// Depends on i2cbs_pkg, i2cbs_step and assert_macros.svh.
`include "assert_macros.svh"

module i2c_master_bit_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: opcode[2:0], write_data[10:3], send_ack[11], sda_sample[12], zero[15:13]
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,
  // tdata: scl_level[0], sda_level[1], busy_res[2], done_res[3], read_byte[11:4],
  //        tgt_acked[12], zero[15:13]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o
);

  i2cbs_pkg::state_t  state_q, state_d;
  i2cbs_pkg::item_t   item;
  i2cbs_pkg::result_t res_d, res_q;
  logic               out_valid_q;
  logic               accept;

  // Unpack the input beat, lowest field first.
  assign item.opcode     = s_tdata_i[2:0];
  assign item.write_data = s_tdata_i[10:3];
  assign item.send_ack   = s_tdata_i[11];
  assign item.sda_sample = s_tdata_i[12];

  // Take a beat whenever the result slot is empty or being drained this cycle.
  assign s_tready_o = !out_valid_q || m_tready_i;
  assign accept     = s_tvalid_i && s_tready_o;

  i2cbs_step u_step (
    .state_i  (state_q),
    .item_i   (item),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Sequencer state advances only on an accepted beat: one tick, one action.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2cbs_pkg::STATE_RST;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Result register: load on accept, drop valid once the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {3'b000, res_q.tgt_acked, res_q.read_byte, res_q.done_res,
                       res_q.busy_res, res_q.sda_level, res_q.scl_level};

  // A finished command never reports busy on the same beat.
  `ASSERT_IMPLIES(a_done_not_busy, out_valid_q && res_q.done_res, !res_q.busy_res)
  // While a command runs, the latched command is one of start, stop, write, read.
  `ASSERT_IMPLIES(a_cmd_valid, state_q.phase != 5'd0,
                  (state_q.command == i2cbs_pkg::OP_START) ||
                  (state_q.command == i2cbs_pkg::OP_STOP)  ||
                  (state_q.command == i2cbs_pkg::OP_WRITE) ||
                  (state_q.command == i2cbs_pkg::OP_READ))
  // Edge commands never run past their fourth action.
  `ASSERT_IMPLIES(a_edge_len,
                  (state_q.command == i2cbs_pkg::OP_START) ||
                  (state_q.command == i2cbs_pkg::OP_STOP),
                  state_q.phase <= i2cbs_pkg::EDGE_LAST)
  // The bit-slot counter is back at SCL low whenever the sequencer is idle.
  `ASSERT_IMPLIES(a_slot_idle, state_q.phase == 5'd0,
                  state_q.slot == i2cbs_pkg::SLOT_SCL_LOW)

endmodule
